FILE: src/tms_pkg.sv
package tms_pkg;

	localparam int unsigned MaxItemsDefault = 1024;
	localparam int unsigned SizeW = 32;
	localparam int unsigned CountW = 11;
	localparam int unsigned AddrW = 1;

	localparam logic [AddrW-1:0] RegTolerance = 1'b0;

	localparam logic MODE_DESIRE = 1'b0;
	localparam logic MODE_OFFER = 1'b1;

	typedef struct packed {
		logic start;
		logic which;
	} sort_cmd_t;

endpackage

FILE: src/tolerance_match_sorted_lists.sv
// Load: one beat per cycle; each beat that fits is written into its store in the cycle it is accepted.
// After the beat with tlast, both lists are insertion sorted with one compare unit and one
// read port and one write port per store; each compare-and-shift step passes ST_SRD and ST_SCMP.
// The two-pointer walk then passes ST_WRD, ST_WWT and ST_WCMP for each step.
// The input is not ready from the last beat until the result beat is taken.
// Reset (arst_n low, asynchronous) clears counts, flags, tolerance and the sequencer.
module tolerance_match_sorted_lists import tms_pkg::*; #(
	parameter int unsigned MAX_ITEMS = MaxItemsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [AddrW+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata, // size_value[31:0]
	input  logic        s_tuser, // mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata, // match_count[10:0], overflow[11], zero fill
	output logic        m_tlast
);

	localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned NW = IW + 1;
	localparam logic [NW-1:0] NMax = NW'(MAX_ITEMS);
	localparam logic [NW:0] CntSat = (NW+1)'(2047);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_SOUT = 4'd1;
	localparam logic [3:0] ST_SRD = 4'd2;
	localparam logic [3:0] ST_SWT = 4'd3;
	localparam logic [3:0] ST_SCMP = 4'd4;
	localparam logic [3:0] ST_WRD = 4'd5;
	localparam logic [3:0] ST_WWT = 4'd6;
	localparam logic [3:0] ST_WCMP = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;
	localparam logic [3:0] ST_SKEY = 4'd9;

	logic [3:0] state_q;
	logic [SizeW-1:0] tol_q;
	logic [NW-1:0] dcnt_q, ocnt_q;
	logic drop_q;
	logic which_q;
	logic [NW-1:0] a_q, b_q;
	logic [SizeW-1:0] key_q;
	logic [NW:0] tally_q;
	logic [CountW-1:0] res_cnt_q;
	logic res_ovf_q;

	logic [IW-1:0] d_waddr, o_waddr, d_raddr, o_raddr;
	logic [SizeW-1:0] d_wdata, o_wdata, d_rdata, o_rdata, r_sel;
	logic d_we, o_we;
	logic [SizeW:0] d_ext, o_ext, tol_ext;
	logic [NW-1:0] n_sel;
	logic accept;
	sort_cmd_t cmd;

	assign pready = 1'b1;
	assign prdata = tol_q;
	assign s_tready = (state_q == ST_LOAD);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast = 1'b1;
	assign m_tdata = {4'd0, res_ovf_q, res_cnt_q};

	assign r_sel = which_q ? o_rdata : d_rdata;
	assign n_sel = which_q ? ocnt_q : dcnt_q;
	assign d_ext = {1'b0, d_rdata};
	assign o_ext = {1'b0, o_rdata};
	assign tol_ext = {1'b0, tol_q};
	assign cmd.start = accept && s_tlast;
	assign cmd.which = MODE_DESIRE;

	always_comb begin
		d_we = 1'b0; o_we = 1'b0;
		d_waddr = dcnt_q[IW-1:0]; o_waddr = ocnt_q[IW-1:0];
		d_wdata = s_tdata[SizeW-1:0]; o_wdata = s_tdata[SizeW-1:0];
		d_raddr = b_q[IW-1:0]; o_raddr = b_q[IW-1:0];
		if (state_q == ST_LOAD) begin
			d_we = accept && (s_tuser == MODE_DESIRE) && (dcnt_q < NMax);
			o_we = accept && (s_tuser == MODE_OFFER) && (ocnt_q < NMax);
		end else if (state_q == ST_SCMP) begin
			// Shift the larger entry up one place, or drop the key in.
			if (b_q != '0 && r_sel > key_q) begin
				d_wdata = r_sel; o_wdata = r_sel;
			end else begin
				d_wdata = key_q; o_wdata = key_q;
			end
			d_waddr = b_q[IW-1:0];
			o_waddr = b_q[IW-1:0];
			d_we = !which_q; o_we = which_q;
		end
		if (state_q == ST_SRD || state_q == ST_SKEY) begin
			d_raddr = (state_q == ST_SKEY) ? a_q[IW-1:0] : IW'(b_q - 1'b1);
			o_raddr = d_raddr;
		end
		if (state_q == ST_WRD || state_q == ST_WWT) begin
			d_raddr = a_q[IW-1:0]; o_raddr = b_q[IW-1:0];
		end
	end

	tms_mem #(.MAX_ITEMS(MAX_ITEMS), .IW(IW)) u_dmem (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);
	tms_mem #(.MAX_ITEMS(MAX_ITEMS), .IW(IW)) u_omem (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	// Sorting: a is the outer index, key_q the entry being inserted, b the hole.
	// ST_SKEY reads entry a; ST_SRD reads entry b-1; ST_SCMP compares and writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; tol_q <= '0; dcnt_q <= '0; ocnt_q <= '0;
			drop_q <= 1'b0; which_q <= 1'b0; a_q <= '0; b_q <= '0;
			key_q <= '0; tally_q <= '0; res_cnt_q <= '0; res_ovf_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[AddrW+1:2] == RegTolerance) begin
				tol_q <= pwdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (s_tuser == MODE_DESIRE) begin
							if (dcnt_q < NMax) dcnt_q <= dcnt_q + 1'b1;
							else drop_q <= 1'b1;
						end else begin
							if (ocnt_q < NMax) ocnt_q <= ocnt_q + 1'b1;
							else drop_q <= 1'b1;
						end
						if (cmd.start) begin
							which_q <= cmd.which;
							a_q <= NW'(1);
							state_q <= ST_SOUT;
						end
					end
				end
				ST_SOUT: begin
					if (a_q < n_sel) begin
						b_q <= a_q;
						state_q <= ST_SKEY;
					end else if (!which_q) begin
						which_q <= 1'b1;
						a_q <= NW'(1);
					end else begin
						a_q <= '0; b_q <= '0; tally_q <= '0;
						state_q <= ST_WRD;
					end
				end
				ST_SKEY: state_q <= ST_SWT;
				ST_SWT: begin
					key_q <= r_sel;
					state_q <= ST_SRD;
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (b_q != '0 && r_sel > key_q) begin
						b_q <= b_q - 1'b1;
						state_q <= ST_SRD;
					end else begin
						a_q <= a_q + 1'b1;
						state_q <= ST_SOUT;
					end
				end
				ST_WRD: begin
					if (a_q < dcnt_q && b_q < ocnt_q) state_q <= ST_WWT;
					else begin
						res_cnt_q <= (tally_q > CntSat) ? CountW'(2047) : CountW'(tally_q);
						res_ovf_q <= drop_q;
						state_q <= ST_OUT;
					end
				end
				ST_WWT: state_q <= ST_WCMP;
				ST_WCMP: begin
					if (o_ext + tol_ext < d_ext) begin
						b_q <= b_q + 1'b1;
					end else if (o_ext > d_ext + tol_ext) begin
						a_q <= a_q + 1'b1;
					end else begin
						a_q <= a_q + 1'b1; b_q <= b_q + 1'b1;
						tally_q <= tally_q + 1'b1;
					end
					state_q <= ST_WRD;
				end
				ST_OUT: begin
					if (m_tready) begin
						dcnt_q <= '0; ocnt_q <= '0; drop_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> !s_tready)
		else $error("ready while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= NMax && ocnt_q <= NMax)
		else $error("count past capacity");
`endif

endmodule

FILE: src/tms_mem.sv
module tms_mem import tms_pkg::*; #(
	parameter int unsigned MAX_ITEMS = MaxItemsDefault,
	parameter int unsigned IW = $clog2(MAX_ITEMS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [SizeW-1:0] wdata,
	input  logic [IW-1:0]    raddr,
	output logic [SizeW-1:0] rdata
);

	logic [SizeW-1:0] mem [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
